@@ design/drm_pkg.sv @@
`timescale 1ns / 1ps
// shared types, field layout and constants for the delta-r reference matcher
// no dependencies; imported by every module of the block

package drm_pkg;

  localparam int NUM_REFS       = 3;
  localparam int MAX_CANDIDATES = 256;

  // field widths
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 2;
  localparam int PT_W     = 16;
  localparam int ETA_W    = 12;
  localparam int PHI_W    = 11;
  localparam int PID_W    = 10;
  localparam int ID_W     = 9;
  localparam int DIST_W   = 25;
  localparam int CAND_W   = 8;
  localparam int REF_IDX_W = 2;
  localparam int CNT_W    = $clog2(MAX_CANDIDATES + 1);

  // input tdata layout, lowest bit first
  localparam int SLOT_LSB   = 0;
  localparam int PT_LSB     = SLOT_LSB + SLOT_W;
  localparam int ETA_LSB    = PT_LSB + PT_W;
  localparam int PHI_LSB    = ETA_LSB + ETA_W;
  localparam int PID_LSB    = PHI_LSB + PHI_W;
  localparam int IN_USED_W  = PID_LSB + PID_W;
  localparam int IN_DATA_W  = ((IN_USED_W + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int OUT_USED_W = REF_IDX_W + 1 + CAND_W;
  localparam int OUT_DATA_W = ((OUT_USED_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_USED_W;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = DIST_W;

  localparam int PHI_PERIOD = 1440;
  localparam int PHI_HALF   = 720;

  localparam logic [DIST_W-1:0] DIST_ONES     = '1;
  localparam logic [DIST_W-1:0] DR2_THR_RESET = DIST_W'(525);
  localparam logic [ID_W-1:0]   ID_A_RESET    = ID_W'(211);
  localparam logic [ID_W-1:0]   ID_B_RESET    = ID_W'(11);

  typedef enum logic [OP_W-1:0] {
    OP_LOAD = 2'd0,
    OP_CAND = 2'd1,
    OP_END  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DR2_THRESHOLD = 2'd0,
    REG_ACCEPTED_ID_A = 2'd1,
    REG_ACCEPTED_ID_B = 2'd2
  } cfg_reg_t;

endpackage

@@ design/delta_r_reference_matcher.sv @@
`timescale 1ns / 1ps
// results of an end-of-event transaction pass the input register and the result buffer,
// then leave one per cycle while tready is high, the last with tlast; other items give none
// throughput: one transaction per cycle through the input register; an end-of-event item
// waits while the three-entry result buffer still drains the previous event
// reset (rst, synchronous): references zero, event state cleared, registers to defaults
// top level; depends on drm_pkg and drm_distance

module delta_r_reference_matcher import drm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // ref_slot, pt_value, eta_value, phi_value, particle_id, zero pad
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // op
  input  logic [OP_W-1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // ref_index, matched, cand_index, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // last_result
  output logic                  m_axis_tlast,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam logic [REF_IDX_W-1:0] LAST_REF = REF_IDX_W'(NUM_REFS - 1);

  // configuration
  logic [DIST_W-1:0] dr2_threshold;
  logic [ID_W-1:0]   accepted_id_a;
  logic [ID_W-1:0]   accepted_id_b;

  // input register
  logic                    in_valid;
  op_t                     in_op;
  logic [SLOT_W-1:0]       in_slot;
  logic [PT_W-1:0]         in_pt;
  logic signed [ETA_W-1:0] in_eta;
  logic signed [PHI_W-1:0] in_phi;
  logic signed [PID_W-1:0] in_pid;

  // references and event state
  logic [PT_W-1:0]         ref_pt   [NUM_REFS];
  logic signed [ETA_W-1:0] ref_eta  [NUM_REFS];
  logic signed [PHI_W-1:0] ref_phi  [NUM_REFS];
  logic [DIST_W-1:0]       best_distance  [NUM_REFS];
  logic [CAND_W-1:0]       best_candidate [NUM_REFS];
  logic [PT_W-1:0]         best_pt        [NUM_REFS];
  logic [NUM_REFS-1:0]     have_best;
  logic [CNT_W-1:0]        cand_count;

  // result buffer
  logic                    busy;
  logic [REF_IDX_W-1:0]    drain_idx;
  logic [NUM_REFS-1:0]     res_matched;
  logic [CAND_W-1:0]       res_cand [NUM_REFS];

  logic [DIST_W-1:0]       dr2 [NUM_REFS];
  logic [NUM_REFS-1:0]     match;
  logic [PID_W-1:0]        pid_abs;
  logic                    id_ok;
  logic                    cand_ok;
  logic                    drain_done;
  logic                    do_proc;

  for (genvar k = 0; k < NUM_REFS; k++) begin : g_ref
    drm_distance u_dist (
      .cand_eta (in_eta),
      .cand_phi (in_phi),
      .ref_eta  (ref_eta[k]),
      .ref_phi  (ref_phi[k]),
      .dr2      (dr2[k])
    );

    // pt window: half the reference pt < candidate pt < twice the reference pt
    assign match[k] = have_best[k] && (best_distance[k] < dr2_threshold)
                      && ({best_pt[k], 1'b0} > {1'b0, ref_pt[k]})
                      && ({1'b0, best_pt[k]} < {ref_pt[k], 1'b0});
  end

  assign pid_abs    = in_pid[PID_W-1] ? PID_W'(-in_pid) : PID_W'(in_pid);
  assign id_ok      = (pid_abs == {1'b0, accepted_id_a}) || (pid_abs == {1'b0, accepted_id_b});
  assign cand_ok    = cand_count < CNT_W'(MAX_CANDIDATES);
  assign drain_done = busy && m_axis_tready && (drain_idx == LAST_REF);
  assign do_proc    = in_valid && ((in_op != OP_END) || !busy || drain_done);

  assign s_axis_tready = !in_valid || do_proc;

  assign m_axis_tvalid = busy;
  assign m_axis_tlast  = drain_idx == LAST_REF;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, res_cand[drain_idx], res_matched[drain_idx],
                          drain_idx};

  // payload of the input register
  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= op_t'(s_axis_tuser);
      in_slot <= s_axis_tdata[SLOT_LSB +: SLOT_W];
      in_pt   <= s_axis_tdata[PT_LSB +: PT_W];
      in_eta  <= s_axis_tdata[ETA_LSB +: ETA_W];
      in_phi  <= s_axis_tdata[PHI_LSB +: PHI_W];
      in_pid  <= s_axis_tdata[PID_LSB +: PID_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dr2_threshold <= DR2_THR_RESET;
      accepted_id_a <= ID_A_RESET;
      accepted_id_b <= ID_B_RESET;
      in_valid      <= 1'b0;
      busy          <= 1'b0;
      drain_idx     <= '0;
      have_best     <= '0;
      cand_count    <= '0;
      for (int k = 0; k < NUM_REFS; k++) begin
        ref_pt[k]         <= '0;
        ref_eta[k]        <= '0;
        ref_phi[k]        <= '0;
        best_distance[k]  <= DIST_ONES;
        best_candidate[k] <= '0;
        best_pt[k]        <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DR2_THRESHOLD: dr2_threshold <= cfg_data[DIST_W-1:0];
          REG_ACCEPTED_ID_A: accepted_id_a <= cfg_data[ID_W-1:0];
          REG_ACCEPTED_ID_B: accepted_id_b <= cfg_data[ID_W-1:0];
          default: ;
        endcase
      end

      if (s_axis_tready) begin
        in_valid <= s_axis_tvalid;
      end

      // result drain; a new end-of-event below takes the buffer over instead
      if (busy && m_axis_tready && !(do_proc && (in_op == OP_END))) begin
        if (drain_idx == LAST_REF) begin
          busy <= 1'b0;
        end else begin
          drain_idx <= drain_idx + REF_IDX_W'(1);
        end
      end

      if (do_proc) begin
        case (in_op)
          OP_LOAD: begin
            if (in_slot < SLOT_W'(NUM_REFS)) begin
              ref_pt[in_slot]  <= in_pt;
              ref_eta[in_slot] <= in_eta;
              ref_phi[in_slot] <= in_phi;
            end
          end
          OP_CAND: begin
            if (cand_ok) begin
              if (id_ok) begin
                for (int k = 0; k < NUM_REFS; k++) begin
                  // strict compare keeps the earlier candidate on a tie
                  if (!have_best[k] || (dr2[k] < best_distance[k])) begin
                    best_distance[k]  <= dr2[k];
                    best_candidate[k] <= cand_count[CAND_W-1:0];
                    best_pt[k]        <= in_pt;
                    have_best[k]      <= 1'b1;
                  end
                end
              end
              cand_count <= cand_count + CNT_W'(1);
            end
          end
          OP_END: begin
            for (int k = 0; k < NUM_REFS; k++) begin
              res_matched[k]    <= match[k];
              res_cand[k]       <= match[k] ? best_candidate[k] : '0;
              best_distance[k]  <= DIST_ONES;
              best_candidate[k] <= '0;
              best_pt[k]        <= '0;
            end
            have_best  <= '0;
            cand_count <= '0;
            busy       <= 1'b1;
            drain_idx  <= '0;
          end
          default: ;
        endcase
      end
    end
  end

endmodule

@@ design/drm_distance.sv @@
`timescale 1ns / 1ps
// squared delta-r between one candidate and one reference, phi wrapped
// depends on drm_pkg

module drm_distance import drm_pkg::*; (
  input  logic signed [ETA_W-1:0] cand_eta,
  input  logic signed [PHI_W-1:0] cand_phi,
  input  logic signed [ETA_W-1:0] ref_eta,
  input  logic signed [PHI_W-1:0] ref_phi,
  output logic [DIST_W-1:0]       dr2
);

  localparam logic signed [PHI_W:0] PHI_HALF_S   = (PHI_W + 1)'(PHI_HALF);
  localparam logic signed [PHI_W:0] PHI_PERIOD_S = (PHI_W + 1)'(PHI_PERIOD);

  logic signed [ETA_W:0]       deta;
  logic signed [PHI_W:0]       dphi_raw;
  logic signed [PHI_W:0]       dphi_wrap;
  logic signed [PHI_W-1:0]     dphi;
  logic signed [2*ETA_W+1:0]   deta_prod;
  logic signed [2*PHI_W-1:0]   dphi_prod;

  assign deta     = {cand_eta[ETA_W-1], cand_eta} - {ref_eta[ETA_W-1], ref_eta};
  assign dphi_raw = {cand_phi[PHI_W-1], cand_phi} - {ref_phi[PHI_W-1], ref_phi};

  // the raw difference stays within one period of the wrapped range
  always_comb begin
    if (dphi_raw >= PHI_HALF_S) begin
      dphi_wrap = dphi_raw - PHI_PERIOD_S;
    end else if (dphi_raw < -PHI_HALF_S) begin
      dphi_wrap = dphi_raw + PHI_PERIOD_S;
    end else begin
      dphi_wrap = dphi_raw;
    end
  end

  assign dphi      = dphi_wrap[PHI_W-1:0];
  assign deta_prod = deta * deta;
  assign dphi_prod = dphi * dphi;
  assign dr2       = DIST_W'(deta_prod[2*ETA_W-1:0]) + DIST_W'(dphi_prod[2*PHI_W-3:0]);

endmodule

@@ design/drm_checker.sv @@
`timescale 1ns / 1ps
// port-level checks on the result stream of the delta-r reference matcher
// depends on drm_pkg; bound to delta_r_reference_matcher below

module drm_checker import drm_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  m_axis_tvalid,
  input logic                  m_axis_tready,
  input logic [OUT_DATA_W-1:0] m_axis_tdata,
  input logic                  m_axis_tlast
);

  localparam logic [REF_IDX_W-1:0] LAST_REF = REF_IDX_W'(NUM_REFS - 1);

  logic [REF_IDX_W-1:0] ref_index;
  logic                 matched;
  logic [CAND_W-1:0]    cand_index;

  assign ref_index  = m_axis_tdata[REF_IDX_W-1:0];
  assign matched    = m_axis_tdata[REF_IDX_W];
  assign cand_index = m_axis_tdata[REF_IDX_W+1 +: CAND_W];

  // results of one event follow back to back in slot order
  a_slot_order: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast
    |=> m_axis_tvalid && (ref_index == $past(ref_index) + REF_IDX_W'(1)))
    else $error("result slot sequence broken");

  a_last_slot: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (ref_index == LAST_REF)))
    else $error("tlast not on the final slot");

  a_unmatched_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !matched |-> cand_index == '0)
    else $error("unmatched result carries a candidate index");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("result valid after reset");

endmodule

bind delta_r_reference_matcher drm_checker u_drm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// testbench for delta_r_reference_matcher: directed and random events checked against
// a scoreboard that predicts the per-reference match results; depends on drm_pkg and the rtl

module tb_top;
  import drm_pkg::*;

  localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS  = 200;
  localparam int NUM_PHASES    = 5;
  localparam int SETTLE_CYCLES = 8;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [SLOT_W-1:0]       slot;
    logic [PT_W-1:0]         pt;
    logic signed [ETA_W-1:0] eta;
    logic signed [PHI_W-1:0] phi;
    logic signed [PID_W-1:0] pid;
  } particle_item_t;

  typedef struct packed {
    logic [REF_IDX_W-1:0] ref_index;
    logic                 matched;
    logic [CAND_W-1:0]    cand_index;
    logic                 last;
  } match_result_t;

  class match_scoreboard;
    logic [DIST_W-1:0]       thr;
    logic [ID_W-1:0]         id_a;
    logic [ID_W-1:0]         id_b;
    logic [PT_W-1:0]         ref_pt[NUM_REFS];
    logic signed [ETA_W-1:0] ref_eta[NUM_REFS];
    logic signed [PHI_W-1:0] ref_phi[NUM_REFS];
    logic [DIST_W-1:0]       best_dist[NUM_REFS];
    logic [CAND_W-1:0]       best_cand[NUM_REFS];
    logic [PT_W-1:0]         best_pt[NUM_REFS];
    bit                      have_best[NUM_REFS];
    int                      cand_count;
    match_result_t           expected_matches[$];
    int                      errors;

    function new();
      thr    = DR2_THR_RESET;
      id_a   = ID_A_RESET;
      id_b   = ID_B_RESET;
      errors = 0;
      foreach (ref_pt[k]) begin
        ref_pt[k]  = '0;
        ref_eta[k] = '0;
        ref_phi[k] = '0;
      end
      clear_event();
    endfunction

    function void clear_event();
      foreach (best_dist[k]) begin
        best_dist[k] = DIST_ONES;
        best_cand[k] = '0;
        best_pt[k]   = '0;
        have_best[k] = 1'b0;
      end
      cand_count = 0;
    endfunction

    // squared delta-r with the phi difference folded into [-720, 719]
    function int unsigned dist_to_ref(logic signed [ETA_W-1:0] eta,
                                      logic signed [PHI_W-1:0] phi, int k);
      int de;
      int dp;
      de = int'(eta) - int'(ref_eta[k]);
      dp = int'(phi) - int'(ref_phi[k]);
      dp = ((dp % PHI_PERIOD) + PHI_PERIOD) % PHI_PERIOD;
      if (dp >= PHI_HALF) dp -= PHI_PERIOD;
      return de * de + dp * dp;
    endfunction

    function void set_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
      case (idx)
        REG_DR2_THRESHOLD: thr  = value[DIST_W-1:0];
        REG_ACCEPTED_ID_A: id_a = value[ID_W-1:0];
        REG_ACCEPTED_ID_B: id_b = value[ID_W-1:0];
        default: ;
      endcase
    endfunction

    function void apply_item(particle_item_t it);
      int unsigned   d;
      int            apid;
      int            c;
      int            r;
      match_result_t res;
      case (it.op)
        OP_LOAD: begin
          if (it.slot < NUM_REFS) begin
            ref_pt[it.slot]  = it.pt;
            ref_eta[it.slot] = it.eta;
            ref_phi[it.slot] = it.phi;
          end
        end
        OP_CAND: begin
          if (cand_count < MAX_CANDIDATES) begin
            apid = int'(it.pid);
            if (apid < 0) apid = -apid;
            if (apid == int'(id_a) || apid == int'(id_b)) begin
              for (int k = 0; k < NUM_REFS; k++) begin
                d = dist_to_ref(it.eta, it.phi, k);
                // strict compare keeps the earlier candidate on a tie
                if (!have_best[k] || d < best_dist[k]) begin
                  best_dist[k] = DIST_W'(d);
                  best_cand[k] = CAND_W'(cand_count);
                  best_pt[k]   = it.pt;
                  have_best[k] = 1'b1;
                end
              end
            end
            cand_count++;
          end
        end
        OP_END: begin
          for (int k = 0; k < NUM_REFS; k++) begin
            c = int'(best_pt[k]);
            r = int'(ref_pt[k]);
            res.ref_index  = REF_IDX_W'(k);
            res.matched    = have_best[k] && best_dist[k] < thr && 2 * c > r && c < 2 * r;
            res.cand_index = res.matched ? best_cand[k] : '0;
            res.last       = (k == NUM_REFS - 1);
            expected_matches = {expected_matches, res};
          end
          clear_event();
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_matches.size();
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(match_result_t got);
      match_result_t want;
      if (expected_matches.size() == 0) begin
        report($sformatf("result for ref %0d with no event pending", got.ref_index));
        return;
      end
      want = expected_matches.pop_front();
      if (got.ref_index !== want.ref_index)
        report($sformatf("ref_index got %0d want %0d", got.ref_index, want.ref_index));
      if (got.matched !== want.matched)
        report($sformatf("ref %0d matched got %0d want %0d", want.ref_index, got.matched,
                         want.matched));
      if (got.cand_index !== want.cand_index)
        report($sformatf("ref %0d cand_index got %0d want %0d", want.ref_index,
                         got.cand_index, want.cand_index));
      if (got.last !== want.last)
        report($sformatf("ref %0d tlast got %0d want %0d", want.ref_index, got.last,
                         want.last));
    endtask
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [OP_W-1:0]       s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  match_scoreboard sb = new();
  bit              stall_on = 1'b1;
  int              rx_stall = 0;
  int              items_sent = 0;

  delta_r_reference_matcher u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #4 clk = ~clk;

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    if (!stall_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(negedge clk) begin : result_sink
    if (rx_stall == 0 && stall_on && $urandom_range(0, 3) == 0) rx_stall = pick_gap();
    if (rx_stall > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin : result_monitor
    match_result_t got;
    if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      got.ref_index  = m_axis_tdata[REF_IDX_W-1:0];
      got.matched    = m_axis_tdata[REF_IDX_W];
      got.cand_index = m_axis_tdata[REF_IDX_W+1 +: CAND_W];
      got.last       = m_axis_tlast;
      sb.check_result(got);
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_item(int op, int slot, int pt, int eta, int phi, int pid);
    particle_item_t it;
    int             gap;
    it.op   = OP_W'(op);
    it.slot = SLOT_W'(slot);
    it.pt   = PT_W'(pt);
    it.eta  = ETA_W'(eta);
    it.phi  = PHI_W'(phi);
    it.pid  = PID_W'(pid);
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.op;
    s_axis_tdata  <= {{(IN_DATA_W - IN_USED_W){1'b0}}, it.pid, it.phi, it.eta, it.pt, it.slot};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    sb.apply_item(it);
    if (it.op != OP_RESERVED) items_sent++;
    @(negedge clk);
  endtask

  // hold the sender until every pending result is out, then let the pipeline settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    sb.set_register(idx, value);
    @(negedge clk);
  endtask

  task automatic write_settings(logic [DIST_W-1:0] thr, logic [ID_W-1:0] ida,
                                logic [ID_W-1:0] idb);
    write_reg(REG_DR2_THRESHOLD, CFG_DATA_W'(thr));
    write_reg(REG_ACCEPTED_ID_A, CFG_DATA_W'(ida));
    write_reg(REG_ACCEPTED_ID_B, CFG_DATA_W'(idb));
    cfg_we <= 1'b0;
  endtask

  // one event: optional reference loads, candidates mostly aimed at a reference, usually an end marker
  task automatic run_event();
    int n;
    int k;
    int pick;
    int id;
    stall_on = ($urandom_range(0, 4) != 0);
    if ($urandom_range(0, 2) != 0) begin
      n = $urandom_range(1, 4);
      repeat (n) begin
        send_item(OP_LOAD,
                  ($urandom_range(0, 9) == 0) ? NUM_REFS : $urandom_range(0, NUM_REFS - 1),
                  ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(8, 2000),
                  $urandom,
                  ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 1439) - 720,
                  $urandom);
      end
    end
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(0, 8);
    repeat (n) begin
      pick = $urandom_range(0, 19);
      k    = $urandom_range(0, NUM_REFS - 1);
      if (pick == 0) begin
        send_item(OP_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else if (pick == 1) begin
        // reference moved in the middle of an event
        send_item(OP_LOAD, k, $urandom_range(8, 2000), $urandom, $urandom, $urandom);
      end else if (pick < 15) begin
        id = ($urandom_range(0, 1) != 0) ? int'(sb.id_a) : int'(sb.id_b);
        if ($urandom_range(0, 1) != 0) id = -id;
        send_item(OP_CAND, $urandom,
                  int'(sb.ref_pt[k]) * $urandom_range(30, 250) / 100,
                  int'(sb.ref_eta[k]) + $urandom_range(0, 50) - 25,
                  int'(sb.ref_phi[k]) + $urandom_range(0, 50) - 25,
                  id);
      end else begin
        send_item(OP_CAND, $urandom, $urandom, $urandom, $urandom, $urandom);
      end
    end
    // an event left open runs on into the next one
    if ($urandom_range(0, 11) != 0)
      send_item(OP_END, $urandom, $urandom, $urandom, $urandom, $urandom);
    if ($urandom_range(0, 9) == 0) wait_drained();
  endtask

  initial begin : stimulus
    int target;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset values of the registers, empty event first
    send_item(OP_END, 0, 0, 0, 0, 0);
    send_item(OP_LOAD, 0, 100, 0, 715, 0);
    send_item(OP_LOAD, 1, 65535, -2048, -720, 0);
    send_item(OP_LOAD, 2, 1, 2047, -1, 0);
    send_item(OP_LOAD, NUM_REFS, 7, 5, 5, 0);
    // close to ref 0 only through the phi wrap
    send_item(OP_CAND, 0, 60, 3, -718, 211);
    // same distance, later: the first one stays
    send_item(OP_CAND, 3, 150, 3, -718, -211);
    send_item(OP_CAND, 0, 100, 0, 715, -512);
    send_item(OP_CAND, 0, 100, 0, 715, 0);
    send_item(OP_CAND, 0, 65535, -2047, 719, 11);
    send_item(OP_CAND, 0, 1, 2047, 0, -11);
    send_item(OP_RESERVED, 3, 65535, -1, -1, -1);
    send_item(OP_END, 0, 0, 0, 0, 0);
    // pt exactly half and exactly twice the reference pt
    send_item(OP_CAND, 0, 50, 0, 715, 211);
    send_item(OP_CAND, 0, 0, 0, 0, 511);
    send_item(OP_END, 0, 0, 0, 0, 0);
    send_item(OP_CAND, 0, 200, 0, 715, 211);
    send_item(OP_END, 0, 0, 0, 0, 0);
    // largest eta gap, phi outside the nominal range
    send_item(OP_LOAD, 0, 0, -2048, -1024, 0);
    send_item(OP_CAND, 0, 65535, 2047, 1023, -211);
    send_item(OP_END, 0, 0, 0, 0, 0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      wait_drained();
      case (phase)
        0: write_settings(DR2_THR_RESET, ID_A_RESET, ID_B_RESET);
        1: write_settings('0, '0, '1);
        2: write_settings(DIST_ONES, '1, '0);
        3: write_settings(DIST_W'($urandom_range(50, 20000)), ID_W'($urandom),
                          ID_W'($urandom));
        default: write_settings(DIST_W'(2000), ID_W'(13), ID_W'(22));
      endcase
      target = items_sent + RANDOM_ITEMS / NUM_PHASES;
      while (items_sent < target) run_event();
    end

    // more candidates than the event can count
    wait_drained();
    write_settings(DIST_ONES, ID_A_RESET, ID_B_RESET);
    stall_on = 1'b1;
    repeat (MAX_CANDIDATES + 6)
      send_item(OP_CAND, $urandom, $urandom_range(1, 4000), $urandom, $urandom,
                ($urandom_range(0, 1) != 0) ? int'(ID_A_RESET) : -int'(ID_B_RESET));
    send_item(OP_END, 0, 0, 0, 0, 0);
    run_event();
    send_item(OP_END, 0, 0, 0, 0, 0);

    wait_drained();
    if (sb.errors == 0) begin
      $display("delta_r_reference_matcher verification clean");
    end else begin
      $display("delta_r_reference_matcher verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("delta_r_reference_matcher verification failed");
    $finish;
  end

endmodule
